// ===== src/cfc_pkg.sv =====
// cfc_pkg: shared constants, result struct and crc byte step for the
// control frame checker; no dependencies
package cfc_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned CrcBytes   = 7;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusShort    = 2'd1;
  localparam logic [1:0] StatusWrongTyp = 2'd2;
  localparam logic [1:0] StatusCrcBad   = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        failed;
    logic        reset_requested;
    logic [31:0] value_bits;
    logic [15:0] computed_crc;
  } res_t;

  // one byte through crc-16-ccitt, msb first, unrolled over eight bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/cfc_in_stage.sv =====
// cfc_in_stage: input register of the control frame checker with its
// valid/stall handshake; depends on nothing but the ports
module cfc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

// ===== src/cfc_frame.sv =====
// cfc_frame: per-frame state (count, running crc, staged fields), the end of
// frame decision and the held fields; uses cfc_pkg
module cfc_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic [7:0]    expected_type_i,
  output cfc_pkg::res_t res_o
);
  import cfc_pkg::*;

  logic [3:0]  cnt_q, cnt_d, cnt_nxt;
  logic [15:0] crc_q, crc_d, crc_nxt;
  logic [7:0]  type_q, type_d, type_nxt;
  logic [1:0]  flags_q, flags_d, flags_nxt;
  logic [31:0] sval_q, sval_d, sval_nxt;
  logic [15:0] rcrc_q, rcrc_d, rcrc_nxt;
  logic        hfail_q, hfail_d;
  logic        hrst_q, hrst_d;
  logic [31:0] hval_q, hval_d;
  logic [1:0]  status;
  logic        active;

  assign active = cnt_q < 4'(FrameBytes);

  // fold this byte into the frame
  always_comb begin
    cnt_nxt   = cnt_q;
    crc_nxt   = crc_q;
    type_nxt  = type_q;
    flags_nxt = flags_q;
    sval_nxt  = sval_q;
    rcrc_nxt  = rcrc_q;
    if (active) begin
      cnt_nxt = cnt_q + 4'd1;
      if (cnt_q < 4'(CrcBytes)) begin
        crc_nxt = crc_byte(crc_q, byte_i);
      end
      unique case (cnt_q)
        4'd0:    type_nxt     = byte_i;
        4'd1:    flags_nxt[0] = |byte_i;
        4'd2:    flags_nxt[1] = |byte_i;
        4'd3:    sval_nxt[7:0]   = byte_i;
        4'd4:    sval_nxt[15:8]  = byte_i;
        4'd5:    sval_nxt[23:16] = byte_i;
        4'd6:    sval_nxt[31:24] = byte_i;
        4'd7:    rcrc_nxt[7:0]   = byte_i;
        default: rcrc_nxt[15:8]  = byte_i;
      endcase
    end
  end

  // end of frame decision
  always_comb begin
    hfail_d = hfail_q;
    hrst_d  = hrst_q;
    hval_d  = hval_q;
    priority if (cnt_nxt < 4'(FrameBytes)) begin
      status = StatusShort;
    end else if (type_nxt != expected_type_i) begin
      status = StatusWrongTyp;
    end else if (rcrc_nxt != crc_nxt) begin
      status  = StatusCrcBad;
      hfail_d = 1'b1;
      hrst_d  = 1'b0;
      hval_d  = '0;
    end else begin
      status  = StatusOk;
      hfail_d = flags_nxt[0];
      hrst_d  = flags_nxt[1];
      hval_d  = sval_nxt;
    end
  end

  always_comb begin
    cnt_d   = cnt_nxt;
    crc_d   = crc_nxt;
    type_d  = type_nxt;
    flags_d = flags_nxt;
    sval_d  = sval_nxt;
    rcrc_d  = rcrc_nxt;
    if (last_i) begin
      cnt_d   = '0;
      crc_d   = CrcInit;
      type_d  = '0;
      flags_d = '0;
      sval_d  = '0;
      rcrc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= CrcInit;
      type_q  <= '0;
      flags_q <= '0;
      sval_q  <= '0;
      rcrc_q  <= '0;
      hfail_q <= 1'b0;
      hrst_q  <= 1'b0;
      hval_q  <= '0;
    end else if (step_i) begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      sval_q  <= sval_d;
      rcrc_q  <= rcrc_d;
      if (last_i) begin
        hfail_q <= hfail_d;
        hrst_q  <= hrst_d;
        hval_q  <= hval_d;
      end
    end
  end

  assign res_o.status          = status;
  assign res_o.failed          = hfail_d;
  assign res_o.reset_requested = hrst_d;
  assign res_o.value_bits      = hval_d;
  assign res_o.computed_crc    = crc_nxt;

endmodule

// ===== src/control_frame_checker.sv =====
// control_frame_checker: top level; input register, frame logic and result
// register for received control frames; uses cfc_pkg, cfc_in_stage, cfc_frame
// path: a last byte accepted into the input register moves on into the result
//   register once that register is free, and out_valid_o rises as it is written
// throughput: one byte per cycle unless a last byte waits on a stalled result
//   register; the running crc takes a full byte per cycle through an unrolled
//   eight-bit step, so that one register loop sets the rate
// reset (rst_ni low, asynchronous): both registers empty, frame state cleared,
//   crc at ffff, held fields and expected type at zero
module control_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: expected type byte
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // status output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        failed_o,
  output logic        reset_requested_o,
  output logic [31:0] value_bits_o,
  output logic [15:0] computed_crc_o
);
  import cfc_pkg::*;

  logic [7:0] exp_type_q;
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       out_free;
  logic       take;
  logic       res_valid;
  res_t       res;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;

  // expected type register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= '0;
    end else if (cfg_we_i) begin
      exp_type_q <= cfg_wdata_i;
    end
  end

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // a middle byte always moves on; a last byte needs room for its status
  assign take      = stg_valid && (!stg_last || out_free);
  assign res_valid = take && stg_last;

  cfc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (take),
    .valid_o     (stg_valid),
    .byte_o      (stg_byte),
    .last_o      (stg_last)
  );

  cfc_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (take),
    .byte_i          (stg_byte),
    .last_i          (stg_last),
    .expected_type_i (exp_type_q),
    .res_o           (res)
  );

  // result register: refills when free, else holds the stalled transaction
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign failed_o          = out_q.failed;
  assign reset_requested_o = out_q.reset_requested;
  assign value_bits_o      = out_q.value_bits;
  assign computed_crc_o    = out_q.computed_crc;

endmodule

// ===== tb/sv/tb_control_frame_checker.sv =====
// tb_control_frame_checker: self-checking bench for the control frame checker
// drives frame bytes from a queue, predicts each status and compares it per field
// depends on cfc_pkg and control_frame_checker
`timescale 1ns / 1ps

module tb_control_frame_checker;
  import cfc_pkg::*;

  localparam int unsigned SettleCycles = 8;     // settle margin after the drain
  localparam int unsigned LongHold     = 300;   // receiver hold-off under pressure
  localparam int unsigned QuietLimit   = 2000;  // cycles without any transaction

  // one byte transaction as offered on the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_xfer_t;

  // frame being assembled by the predictor
  typedef struct packed {
    logic [3:0]  n_bytes;
    logic [15:0] crc;
    logic [7:0]  type_byte;
    logic        fail_flag;
    logic        rst_flag;
    logic [31:0] value;
    logic [15:0] crc_rx;
  } frame_acc_t;

  localparam frame_acc_t FrameIdle = '{n_bytes: 4'd0, crc: CrcInit, type_byte: 8'h00,
                                       fail_flag: 1'b0, rst_flag: 1'b0, value: 32'h0,
                                       crc_rx: 16'h0000};

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // every block input starts at a known value
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  res_status;
  logic        res_failed;
  logic        res_reset_req;
  logic [31:0] res_value;
  logic [15:0] res_crc;

  // byte transactions still to be offered, and statuses still to arrive
  byte_xfer_t tx_q[$];
  res_t       awaited_status[$];

  // predictor state: open frame, held fields, copy of the expected type register
  frame_acc_t  acc = FrameIdle;
  logic        held_failed = 1'b0;
  logic        held_rst    = 1'b0;
  logic [31:0] held_value  = 32'h0;
  logic [7:0]  type_cfg    = 8'h00;

  // idling knobs, set by the stimulus between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;

  // progress and failure counters
  int unsigned bytes_taken  = 0;
  int unsigned status_taken = 0;
  int unsigned bad_results  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  control_frame_checker uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .last_byte_i       (last_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (res_status),
    .failed_o          (res_failed),
    .reset_requested_o (res_reset_req),
    .value_bits_o      (res_value),
    .computed_crc_o    (res_crc)
  );

  // crc-16-ccitt, one input bit at a time: feedback is top bit xor data bit
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  // predictor: absorb one accepted byte, queue a status on the frame's last byte
  function automatic void take_frame_byte(input logic [7:0] b, input logic last);
    res_t st;
    if (acc.n_bytes < FrameBytes) begin
      if (acc.n_bytes < CrcBytes) begin
        acc.crc = crc16_step(acc.crc, b);
      end
      case (acc.n_bytes)
        4'd0: acc.type_byte = b;
        4'd1: acc.fail_flag = |b;
        4'd2: acc.rst_flag  = |b;
        4'd3, 4'd4, 4'd5, 4'd6: acc.value[8*(acc.n_bytes-3) +: 8] = b;
        4'd7: acc.crc_rx[7:0] = b;
        default: acc.crc_rx[15:8] = b;
      endcase
      acc.n_bytes++;
    end
    // bytes past the ninth only matter for their last mark
    if (last) begin
      if (acc.n_bytes < FrameBytes) begin
        st.status = StatusShort;
      end else if (acc.type_byte != type_cfg) begin
        st.status = StatusWrongTyp;
      end else if (acc.crc_rx != acc.crc) begin
        // corrupted frame forces the safe values
        st.status   = StatusCrcBad;
        held_failed = 1'b1;
        held_rst    = 1'b0;
        held_value  = 32'h0;
      end else begin
        st.status   = StatusOk;
        held_failed = acc.fail_flag;
        held_rst    = acc.rst_flag;
        held_value  = acc.value;
      end
      st.failed          = held_failed;
      st.reset_requested = held_rst;
      st.value_bits      = held_value;
      st.computed_crc    = acc.crc;
      awaited_status.push_back(st);
      acc = FrameIdle;
    end
  endfunction

  // build a frame with a correct crc (then xor-ed with crc_flip) and queue len bytes of it;
  // shorter lengths truncate, longer ones append random tail bytes
  function automatic void queue_frame(input logic [7:0] frame_type, input logic [47:0] payload,
                                      input logic [15:0] crc_flip, input int unsigned len);
    logic [7:0]  body [9];
    logic [15:0] crc;
    crc     = CrcInit;
    body[0] = frame_type;
    for (int i = 1; i < 7; i++) body[i] = payload[8*(i-1) +: 8];
    for (int i = 0; i < 7; i++) crc = crc16_step(crc, body[i]);
    crc ^= crc_flip;
    body[7] = crc[7:0];
    body[8] = crc[15:8];
    for (int i = 0; i < len; i++) begin
      tx_q.push_back('{data: (i < 9) ? body[i] : 8'($urandom), last: (i == len - 1)});
    end
  endfunction

  // mostly well-formed frames for the current type, the rest broken in various ways
  function automatic void random_frame();
    logic [47:0] payload;
    logic [15:0] flip;
    int unsigned pick;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(3))
        0: payload[8*i +: 8] = 8'h00;
        1: payload[8*i +: 8] = 8'hFF;
        default: payload[8*i +: 8] = 8'($urandom);
      endcase
    end
    flip = $urandom_range(1) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    pick = $urandom_range(99);
    if (pick < 70) begin
      queue_frame(type_cfg, payload, 16'h0000, 9);
    end else if (pick < 78) begin
      queue_frame(type_cfg, payload, 16'($urandom_range(1, 65535)), 9);
    end else if (pick < 86) begin
      queue_frame(type_cfg ^ 8'($urandom_range(1, 255)), payload, flip, 9);
    end else if (pick < 93) begin
      queue_frame(type_cfg, payload, flip, $urandom_range(1, 8));
    end else begin
      queue_frame(type_cfg, payload, flip, $urandom_range(10, 14));
    end
  endfunction

  // byte driver: offers the next queued byte once the current one is taken
  always @(posedge clk) begin : byte_driver
    logic       busy;
    byte_xfer_t cur;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        take_frame_byte(data_byte, last_byte);
        bytes_taken++;
        busy = 1'b0;
      end
      // a stalled byte stays put; otherwise offer a new one or idle
      if (!busy) begin
        if (tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = tx_q.pop_front();
          in_valid  <= 1'b1;
          data_byte <= cur.data;
          last_byte <= cur.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // status monitor: checks each status transaction, then picks the next stall
  always @(posedge clk) begin : status_monitor
    res_t        got;
    res_t        want;
    int unsigned hold_seen;
    int unsigned hold_left;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        status_taken++;
        got = {res_status, res_failed, res_reset_req, res_value, res_crc};
        if (awaited_status.size() == 0) begin
          if (bad_results < 10) begin
            $display("unexpected status transaction: st=%0d f=%b r=%b v=%h crc=%h",
                     got.status, got.failed, got.reset_requested, got.value_bits,
                     got.computed_crc);
          end
          bad_results++;
        end else begin
          want = awaited_status.pop_front();
          if (got.status !== want.status || got.failed !== want.failed ||
              got.reset_requested !== want.reset_requested ||
              got.value_bits !== want.value_bits || got.computed_crc !== want.computed_crc) begin
            if (bad_results < 10) begin
              $display("status %0d differs: want st=%0d f=%b r=%b v=%h crc=%h",
                       status_taken, want.status, want.failed, want.reset_requested,
                       want.value_bits, want.computed_crc);
              $display("                     got st=%0d f=%b r=%b v=%h crc=%h",
                       got.status, got.failed, got.reset_requested, got.value_bits,
                       got.computed_crc);
            end
            bad_results++;
          end
        end
      end
      // a new hold request starts a long hold-off, counted down here
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // wait until every byte is taken and every status has come, then let it settle
  task automatic drain_all();
    while (tx_q.size() != 0 || in_valid || awaited_status.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one phase: write the type register while idle, set idling, run frames, drain
  task automatic run_phase(input logic [7:0] type_val, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned frames,
                           input logic long_hold);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= type_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    type_cfg   = type_val;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) begin
      hold_req++;
    end
    repeat (frames) random_frame();
    drain_all();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames with the register at its reset value
    // all-ones value with both flags set, correct crc
    queue_frame(8'h00, 48'hFFFF_FFFF_01FF, 16'h0000, 9);
    // last mark on the very first byte: too short
    queue_frame(8'h00, 48'h0, 16'h0000, 1);
    // all-zero payload with a corrupted crc
    queue_frame(8'h00, 48'h0, 16'h8001, 9);
    // wrong type with a trailing byte past the ninth
    queue_frame(8'hFF, 48'h1234_5678_0000, 16'h0000, 10);
    repeat (20) random_frame();
    drain_all();

    // random phases across register settings and idling patterns
    run_phase(8'hFF, 67, 0, 30, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 0, 67, 30, 1'b0);
    run_phase(8'h5A, 6, 6, 30, 1'b0);
    // pressure: receiver holds off while the sender keeps offering,
    // then the sender has paused until everything came back
    run_phase(8'h00, 0, 0, 20, 1'b1);
    run_phase(8'($urandom), 0, 67, 15, 1'b0);

    if (bad_results == 0 && awaited_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: ends the run when work is outstanding but nothing moves
  initial begin : watchdog
    int unsigned quiet;
    int unsigned seen;
    quiet = 0;
    seen  = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk);
      if (bytes_taken + status_taken != seen ||
          !(in_valid || tx_q.size() != 0 || awaited_status.size() != 0)) begin
        seen  = bytes_taken + status_taken;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cfc_pkg.sv
src/cfc_in_stage.sv
src/cfc_frame.sv
src/control_frame_checker.sv
tb/sv/tb_control_frame_checker.sv
